@@ hdl/uvl_pkg.sv @@
// shared types and codes for the unique value list
package uvl_pkg;

    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 7;

    localparam logic [1:0] REQ_PUSH   = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_POP    = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_DUP     = 3'd1,
        ST_FULL    = 3'd2,
        ST_MISSING = 3'd3,
        ST_EMPTY   = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_CALC  = 2'd1,
        S_APPLY = 2'd2
    } t_state;

    typedef struct packed {
        logic [1:0]                req_type;
        logic signed [VALUE_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
    } t_out;

    // per-cell control decoded by the top level
    typedef struct packed {
        logic live;
        logic load;
        logic shift;
    } t_cell_ctl;

endpackage

@@ hdl/uvl_cell.sv @@
// one list slot: holds an entry, compares it, loads or takes its upper neighbor
module uvl_cell (
    input  logic                          i_clk,
    input  uvl_pkg::t_cell_ctl            i_ctl,
    input  logic [uvl_pkg::VALUE_W-1:0]   i_key,
    input  logic [uvl_pkg::VALUE_W-1:0]   i_next_entry,
    output logic [uvl_pkg::VALUE_W-1:0]   o_entry,
    output logic                          o_match
);
    import uvl_pkg::*;

    logic [VALUE_W-1:0] r_entry;
    logic [VALUE_W-1:0] n_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.load) begin
            n_entry = i_key;
        end else if (i_ctl.shift) begin
            n_entry = i_next_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    // stale slots above the count never match
    assign o_match = i_ctl.live && (r_entry == i_key);

endmodule

@@ hdl/unique_value_list.sv @@
// top level of the unique value list: control, count and the row of cells
//
// The block keeps up to CAPACITY distinct 32-bit values in insertion order, one per cell.
// A push appends a value unless it is already live (status duplicate, checked first) or
// the list is full; a remove finds the value, drops it and every later cell takes the
// entry of its upper neighbor; a pop drops the newest entry. Each request
// beat gives one result beat with a status and the new count (low 7 bits). A request
// passes S_CALC, in which all live cells compare against the value at once and the
// match position is registered, then S_APPLY, in which the cells update and the result
// register is loaded. The next request is taken in S_APPLY, so a new request is only
// accepted once the last one is being applied; a stalled result holds the update
// cycle until the result register is free. No clearing pass is needed after reset.
module unique_value_list #(
    parameter int CAPACITY = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  uvl_pkg::t_in   i_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output uvl_pkg::t_out  o_out
);
    import uvl_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    // control state
    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_out_valid;
    logic               n_out_valid;

    // payload registers
    t_in                r_req;
    logic               r_hit;
    logic [IDX_W-1:0]   r_pos;
    t_out               r_out;
    t_out               n_out;

    // handshake and update strobes
    logic               in_beat;
    logic               out_free;
    logic               do_apply;
    logic               apply_push;
    logic               apply_remove;

    // cell row
    logic [VALUE_W-1:0] cell_entry [CAPACITY];
    logic [VALUE_W-1:0] cell_next  [CAPACITY];
    logic [CAPACITY-1:0] cell_match;
    t_cell_ctl          cell_ctl   [CAPACITY];
    logic               any_match;
    logic [IDX_W-1:0]   match_pos;
    logic [CNT_W+COUNT_W-1:0] count_ext;

    assign out_free = !r_out_valid || i_out_ready;
    assign in_beat  = i_in_valid && o_in_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                n_state = S_APPLY;
            end
            S_APPLY: begin
                if (out_free) begin
                    n_state = i_in_valid ? S_CALC : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready = 1'b0;
        do_apply   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
            end
            S_CALC: begin
                o_in_ready = 1'b0;
            end
            S_APPLY: begin
                o_in_ready = out_free;
                do_apply   = out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // request decision, using the registered match
    always_comb begin
        apply_push   = 1'b0;
        apply_remove = 1'b0;
        n_count      = r_count;
        n_out.status = ST_OK;
        case (r_req.req_type)
            REQ_PUSH: begin
                if (r_hit) begin
                    n_out.status = ST_DUP;
                end else if (r_count == CNT_W'(CAPACITY)) begin
                    n_out.status = ST_FULL;
                end else begin
                    apply_push = do_apply;
                    n_count    = r_count + CNT_W'(1);
                end
            end
            REQ_REMOVE: begin
                if (!r_hit) begin
                    n_out.status = ST_MISSING;
                end else begin
                    apply_remove = do_apply;
                    n_count      = r_count - CNT_W'(1);
                end
            end
            REQ_POP: begin
                if (r_count == '0) begin
                    n_out.status = ST_EMPTY;
                end else begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            default: begin
                n_out.status = ST_OK;
            end
        endcase
        count_ext   = {{COUNT_W{1'b0}}, n_count};
        n_out.count = count_ext[COUNT_W-1:0];
    end

    // result register: a waiting result leaves while the next beat comes in
    always_comb begin
        n_out_valid = r_out_valid;
        if (do_apply) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (do_apply) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_req <= i_in;
        end
        if (r_state == S_CALC) begin
            r_hit <= any_match;
            r_pos <= match_pos;
        end
        if (do_apply) begin
            r_out <= n_out;
        end
    end

    // live values are distinct, so at most one cell matches: or its index together
    always_comb begin
        any_match = |cell_match;
        match_pos = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (cell_match[i]) begin
                match_pos = match_pos | IDX_W'(i);
            end
        end
    end

    // row of cells, each taking its upper neighbor on a remove
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        always_comb begin
            cell_ctl[g].live  = CNT_W'(g) < r_count;
            cell_ctl[g].load  = apply_push && (CNT_W'(g) == r_count);
            cell_ctl[g].shift = apply_remove && (IDX_W'(g) >= r_pos);
        end

        if (g == CAPACITY - 1) begin : g_last
            assign cell_next[g] = cell_entry[g];
        end else begin : g_mid
            assign cell_next[g] = cell_entry[g+1];
        end

        uvl_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (cell_ctl[g]),
            .i_key        (r_req.value),
            .i_next_entry (cell_next[g]),
            .o_entry      (cell_entry[g]),
            .o_match      (cell_match[g])
        );
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
